// ===== hw/rtl/plt_pkg.sv =====
package plt_pkg;

    // Default number of breakpoints held by the table
    localparam int TABLE_DEPTH_DEF = 64;

    // Item opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_INSERTED    = 3'd0;
    localparam logic [2:0] ST_OVERWRITTEN = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_HIT         = 3'd3;
    localparam logic [2:0] ST_INTERP      = 3'd4;
    localparam logic [2:0] ST_RANGE       = 3'd5;

    // Quotient width of the interpolation divide
    localparam int QUO_W = 16;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic        ins;     // insert item in execution this cycle
        logic        clr;     // clear item in execution this cycle
        logic        any_eq;  // some cell already holds the key
        logic        full;    // last cell is occupied
        logic [31:0] key;
        logic [15:0] val;
    } cell_ctl_t;

    // Per-cell compare status
    typedef struct packed {
        logic valid;
        logic lt;      // stored key below the item key
        logic eq;      // stored key equals the item key
        logic is_pos;  // first cell whose key is not below the item key
    } cell_stat_t;

endpackage

// ===== hw/rtl/plt_cell.sv =====
module plt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  plt_pkg::cell_ctl_t  ctl,
    input  logic                prev_lt,
    input  logic                prev_valid,
    input  logic [31:0]         prev_key,
    input  logic [15:0]         prev_val,
    output plt_pkg::cell_stat_t stat,
    output logic [31:0]         key,
    output logic [15:0]         val
);
    import plt_pkg::*;

    logic        valid_reg;
    logic [31:0] key_reg;
    logic [15:0] val_reg;
    logic        lt;
    logic        eq;
    logic        is_pos;
    logic        shift;

    // Compare against the broadcast key
    always_comb
    begin
        lt     = valid_reg && (key_reg < ctl.key);
        eq     = valid_reg && (key_reg == ctl.key);
        is_pos = !lt && prev_lt;
        shift  = ctl.ins && !ctl.any_eq && !ctl.full && !lt;
    end

    assign stat = '{valid: valid_reg, lt: lt, eq: eq, is_pos: is_pos};
    assign key  = key_reg;
    assign val  = val_reg;

    // Occupancy: cleared by a clear item, moves up with a shifting insert
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= is_pos ? 1'b1 : prev_valid;
        end
    end

    // Point storage: overwrite on match, otherwise take new point or neighbor
    always_ff @(posedge clk)
    begin
        if (ctl.ins && ctl.any_eq && eq)
        begin
            val_reg <= ctl.val;
        end
        else if (shift)
        begin
            key_reg <= is_pos ? ctl.key : prev_key;
            val_reg <= is_pos ? ctl.val : prev_val;
        end
    end

endmodule

// ===== hw/rtl/plt_divider.sv =====
module plt_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [15:0] quo
);
    import plt_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic [31:0]      rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [32:0]      trial;
    logic [32:0]      diff;

    // One quotient bit a cycle; the high part of num is already below den
    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        diff      = trial - {1'b0, den};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = num[47:QUO_W];
            quo_next  = num[QUO_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(QUO_W - 1));
    assign quo  = quo_next;

endmodule

// ===== hw/rtl/piecewise_linear_table_interp.sv =====
// Insert, clear and unused opcodes go from accept through S_EXEC and S_DONE to the
// output register, as does a query on a hit or out of range; an interpolated query
// passes S_EXEC, S_MUL, S_ADD, S_DIV and S_DONE. Only one item is in flight at a time,
// and a stalled result holds the next item off.
// The extra states of an interpolation are multiply, add and 16 divider steps.
// Reset (rst_n, async active low) empties the table and the output register.
module piecewise_linear_table_interp #(
    parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // opcode[1:0], key[33:2], point_value[49:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status[2:0], result_value[18:3]
);
    import plt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  op_reg;
    logic [31:0] key_reg;
    logic [15:0] pval_reg;
    logic [2:0]  status_reg, status_next;
    logic [15:0] res_reg, res_next;
    logic [31:0] lo_key_reg, hi_key_reg;
    logic [15:0] lo_val_reg, hi_val_reg;
    logic [47:0] prod1_reg, prod2_reg;
    logic [31:0] den_reg;
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [15:0] out_value_reg;

    cell_ctl_t   ctl;
    cell_stat_t  stat [TABLE_DEPTH];
    logic [31:0] ckey [TABLE_DEPTH];
    logic [15:0] cval [TABLE_DEPTH];

    logic        any_eq;
    logic        hi_ok;
    logic [15:0] hit_val;
    logic [31:0] lo_key, hi_key;
    logic [15:0] lo_val, hi_val;
    logic        div_start, div_done;
    logic [15:0] div_quo;
    logic [31:0] d1, d2;

    assign s_axis_tready = (state_reg == S_IDLE);

    // Gather across the cells: match and the neighbors around the insert position
    always_comb
    begin
        any_eq  = 1'b0;
        hi_ok   = 1'b0;
        hit_val = '0;
        lo_key  = '0;
        hi_key  = '0;
        lo_val  = '0;
        hi_val  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            any_eq  = any_eq | stat[i].eq;
            hit_val = hit_val | (stat[i].eq ? cval[i] : 16'd0);
        end
        for (int i = 1; i < TABLE_DEPTH; i++)
        begin
            if (stat[i].is_pos && stat[i].valid)
            begin
                hi_ok  = 1'b1;
                hi_key = hi_key | ckey[i];
                hi_val = hi_val | cval[i];
                lo_key = lo_key | ckey[i-1];
                lo_val = lo_val | cval[i-1];
            end
        end
    end

    assign ctl = '{ins:    (state_reg == S_EXEC) && (op_reg == OP_INSERT),
                   clr:    (state_reg == S_EXEC) && (op_reg == OP_CLEAR),
                   any_eq: any_eq,
                   full:   stat[TABLE_DEPTH-1].valid,
                   key:    key_reg,
                   val:    pval_reg};

    // Row of cells, each handing its point to the next one up on insert
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            plt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_lt    (1'b1),
                .prev_valid (1'b0),
                .prev_key   (32'd0),
                .prev_val   (16'd0),
                .stat       (stat[g]),
                .key        (ckey[g]),
                .val        (cval[g])
            );
        end
        else
        begin : g_rest
            plt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_lt    (stat[g-1].lt),
                .prev_valid (stat[g-1].valid),
                .prev_key   (ckey[g-1]),
                .prev_val   (cval[g-1]),
                .stat       (stat[g]),
                .key        (ckey[g]),
                .val        (cval[g])
            );
        end
    end

    assign d1 = key_reg - lo_key_reg;
    assign d2 = hi_key_reg - key_reg;
    assign div_start = (state_reg == S_ADD);

    plt_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod1_reg + prod2_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        res_next    = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_DONE;
                priority if (op_reg == OP_INSERT)
                begin
                    if (any_eq)
                        status_next = ST_OVERWRITTEN;
                    else if (ctl.full)
                        status_next = ST_FULL;
                    else
                        status_next = ST_INSERTED;
                end
                else if (op_reg == OP_CLEAR)
                begin
                    status_next = ST_INSERTED;
                end
                else if (op_reg == OP_QUERY)
                begin
                    if (any_eq)
                    begin
                        status_next = ST_HIT;
                        res_next    = hit_val;
                    end
                    else if (hi_ok)
                    begin
                        status_next = ST_INTERP;
                        state_next  = S_MUL;
                    end
                    else
                    begin
                        status_next = ST_RANGE;
                    end
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            S_MUL:   state_next = S_ADD;
            S_ADD:   state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        res_reg    <= res_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg   <= s_axis_tdata[1:0];
            key_reg  <= s_axis_tdata[33:2];
            pval_reg <= s_axis_tdata[49:34];
        end
        if (state_reg == S_EXEC)
        begin
            lo_key_reg <= lo_key;
            hi_key_reg <= hi_key;
            lo_val_reg <= lo_val;
            hi_val_reg <= hi_val;
        end
        if (state_reg == S_MUL)
        begin
            prod1_reg <= 48'(lo_val_reg) * 48'(d2);
            prod2_reg <= 48'(hi_val_reg) * 48'(d1);
            den_reg   <= hi_key_reg - lo_key_reg;
        end
        if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
        begin
            out_status_reg <= status_reg;
            out_value_reg  <= res_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_value_reg, out_status_reg};

endmodule

// ===== hw/rtl/plt_checker.sv =====
module plt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    import plt_pkg::*;

    // A result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    // Only defined status codes leave the block
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_RANGE)
        else $error("undefined status");

    // Table updates and misses carry a zero value
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == ST_INSERTED ||
        m_axis_tdata[2:0] == ST_OVERWRITTEN || m_axis_tdata[2:0] == ST_FULL ||
        m_axis_tdata[2:0] == ST_RANGE) |-> m_axis_tdata[18:3] == 16'd0)
        else $error("nonzero value on non-answer result");

    // One item in flight: no accept right after an accept
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

endmodule

bind piecewise_linear_table_interp plt_checker u_plt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
